// ----- rtl/core/tsr_pkg.sv -----
`default_nettype none

package tsr_pkg;

    localparam int SYM_W = 5;

    typedef enum logic [1:0] {
        MODE_MATCH = 2'd0,
        MODE_DROP  = 2'd1,
        MODE_COPY  = 2'd2
    } match_mode_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } tsr_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_match;
        logic out_busy;
    } tsr_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tsr_ram.sv -----
`default_nettype none

module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/tsr_ctrl.sv -----
`default_nettype none

module tsr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tsr_pkg::tsr_status_t status,
    output tsr_pkg::tsr_cmd_t         cmd
);
    import tsr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   exec_ok;

    // A text item waits in execution until the result register has room.
    assign exec_ok = !(status.is_match && status.out_busy);

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                    ready_next = 1'b0;
                end
            end
            ST_EXEC: begin
                if (exec_ok) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready    = ready_reg;
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.accept = ready_reg && s_valid;
    assign cmd.exec   = (state_reg == ST_EXEC) && exec_ok;

endmodule

`default_nettype wire

// ----- rtl/core/tsr_datapath.sv -----
`default_nettype none

module tsr_datapath #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tsr_pkg::tsr_cmd_t          cmd,
    output tsr_pkg::tsr_status_t            status,
    input  wire logic                       s_op,
    input  wire logic [tsr_pkg::SYM_W-1:0]  s_symbol,
    input  wire logic                       s_word_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [tsr_pkg::SYM_W-1:0]  m_out_symbol,
    output logic                            m_kept,
    output logic                            m_word_end,
    output logic                            m_table_overflow
);
    import tsr_pkg::*;

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int CW    = $clog2(DEPTH);
    localparam int AW    = 9;

    // Item registers.
    logic             op_reg;
    logic [SYM_W-1:0] sym_reg;
    logic             last_reg;

    // Trie and matcher state.
    logic [NW:0]      nodes_used_reg, nodes_used_next;
    logic [NW-1:0]    load_cursor_reg, load_cursor_next;
    logic             load_skip_reg, load_skip_next;
    logic [NW-1:0]    match_cursor_reg, match_cursor_next;
    match_mode_t      mode_reg, mode_next;
    logic             overflow_reg, overflow_next;
    logic [CW-1:0]    clr_cnt_reg;

    // Result register.
    logic             m_valid_reg, m_valid_next;
    logic [SYM_W-1:0] out_sym_reg;
    logic             kept_reg, kept_next;
    logic             word_end_reg;
    logic             ovf_out_reg;

    // Address path.
    logic             a_op;
    logic [SYM_W-1:0] a_sym;
    logic             a_sym_ok;
    logic [NW-1:0]    a_cur;
    logic [CW-1:0]    slot;

    // Memory ports.
    logic             child_we;
    logic [CW-1:0]    child_wa;
    logic [NW-1:0]    child_wd;
    logic [NW-1:0]    child_rd;
    logic             mark_we;
    logic [NW-1:0]    mark_wa;
    logic [0:0]       mark_rd;

    // Execution terms.
    logic             sym_ok;
    logic             child_zero;
    logic             table_full;
    logic             need_node;
    logic             skip_now;
    logic [NW-1:0]    cursor_new;
    logic             exec_load;
    logic             exec_match;

    assign a_op     = cmd.accept ? s_op : op_reg;
    assign a_sym    = cmd.accept ? s_symbol : sym_reg;
    assign a_sym_ok = {{(AW-SYM_W){1'b0}}, a_sym} < AW'(ALPHABET_SIZE);
    assign a_cur    = a_op ? match_cursor_reg : load_cursor_reg;
    assign slot     = CW'(a_cur) * CW'(ALPHABET_SIZE) + (a_sym_ok ? CW'(a_sym) : '0);

    assign sym_ok     = {{(AW-SYM_W){1'b0}}, sym_reg} < AW'(ALPHABET_SIZE);
    assign child_zero = (child_rd == '0);
    assign table_full = (nodes_used_reg == (NW+1)'(NODE_COUNT));
    assign need_node  = !load_skip_reg && sym_ok && child_zero;
    assign skip_now   = load_skip_reg || !sym_ok || (need_node && table_full);
    assign cursor_new = skip_now ? load_cursor_reg
                      : (child_zero ? nodes_used_reg[NW-1:0] : child_rd);
    assign exec_load  = cmd.exec && !op_reg;
    assign exec_match = cmd.exec && op_reg;

    // The clearing pass after reset shares the write ports with insertion.
    assign child_we = cmd.clear || (exec_load && need_node && !table_full);
    assign child_wa = cmd.clear ? clr_cnt_reg : slot;
    assign child_wd = cmd.clear ? '0 : nodes_used_reg[NW-1:0];
    assign mark_we  = (cmd.clear && (clr_cnt_reg < CW'(NODE_COUNT)))
                    || (exec_load && last_reg && !skip_now);
    assign mark_wa  = cmd.clear ? clr_cnt_reg[NW-1:0] : cursor_new;

    tsr_ram #(
        .WIDTH (NW),
        .DEPTH (DEPTH)
    ) u_child_ram (
        .aclk    (aclk),
        .wr_en   (child_we),
        .wr_addr (child_wa),
        .wr_data (child_wd),
        .rd_addr (slot),
        .rd_data (child_rd)
    );

    tsr_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_mark_ram (
        .aclk    (aclk),
        .wr_en   (mark_we),
        .wr_addr (mark_wa),
        .wr_data (1'b1 & !cmd.clear),
        .rd_addr (match_cursor_reg),
        .rd_data (mark_rd)
    );

    always_comb begin
        nodes_used_next   = nodes_used_reg;
        load_cursor_next  = load_cursor_reg;
        load_skip_next    = load_skip_reg;
        match_cursor_next = match_cursor_reg;
        mode_next         = mode_reg;
        overflow_next     = overflow_reg;
        kept_next         = kept_reg;
        m_valid_next      = m_valid_reg && !m_ready;

        if (exec_load) begin
            if (need_node && table_full) begin
                overflow_next = 1'b1;
            end
            if (need_node && !table_full) begin
                nodes_used_next = nodes_used_reg + 1'b1;
            end
            if (last_reg) begin
                load_cursor_next = '0;
                load_skip_next   = 1'b0;
            end else begin
                load_cursor_next = cursor_new;
                load_skip_next   = skip_now;
            end
        end

        if (exec_match) begin
            m_valid_next = 1'b1;
            unique case (mode_reg)
                MODE_MATCH: begin
                    if (mark_rd[0]) begin
                        mode_next = MODE_DROP;
                        kept_next = 1'b0;
                    end else begin
                        kept_next = 1'b1;
                        if (!sym_ok || child_zero) begin
                            mode_next = MODE_COPY;
                        end else begin
                            match_cursor_next = child_rd;
                        end
                    end
                end
                MODE_DROP: kept_next = 1'b0;
                default:   kept_next = 1'b1;
            endcase
            if (last_reg) begin
                match_cursor_next = '0;
                mode_next         = MODE_MATCH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodes_used_reg   <= (NW+1)'(1);
            load_cursor_reg  <= '0;
            load_skip_reg    <= 1'b0;
            match_cursor_reg <= '0;
            mode_reg         <= MODE_MATCH;
            overflow_reg     <= 1'b0;
            clr_cnt_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            nodes_used_reg   <= nodes_used_next;
            load_cursor_reg  <= load_cursor_next;
            load_skip_reg    <= load_skip_next;
            match_cursor_reg <= match_cursor_next;
            mode_reg         <= mode_next;
            overflow_reg     <= overflow_next;
            m_valid_reg      <= m_valid_next;
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_op;
            sym_reg  <= s_symbol;
            last_reg <= s_word_last;
        end
        kept_reg <= kept_next;
        if (exec_match) begin
            out_sym_reg  <= sym_reg;
            word_end_reg <= last_reg;
            ovf_out_reg  <= overflow_reg;
        end
    end

    assign status.clear_last = (clr_cnt_reg == CW'(DEPTH - 1));
    assign status.is_match   = op_reg;
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign m_valid          = m_valid_reg;
    assign m_out_symbol     = out_sym_reg;
    assign m_kept           = kept_reg;
    assign m_word_end       = word_end_reg;
    assign m_table_overflow = ovf_out_reg;

`ifndef ASSERT_OFF
    a_nodes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (nodes_used_reg != '0) && (nodes_used_reg <= (NW+1)'(NODE_COUNT)))
        else $error("node count out of range");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    a_cursor_allocated: assert property (@(posedge aclk) disable iff (!aresetn)
        ((NW+1)'(match_cursor_reg) < nodes_used_reg)
        && ((NW+1)'(load_cursor_reg) < nodes_used_reg))
        else $error("cursor points at an unallocated node");

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !exec_match)
        else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/trie_shortest_root_replacer.sv -----
// An item is accepted while idle and executed in the following state; a text item waits
// there for room in the result register, and its result is registered as it executes.
// No new item is accepted until the last has executed, as the child table is read
// through a register before the next cursor is known. Reset: synchronous, active low.
// After reset, the child table and end marks are cleared before any item is accepted.
`default_nettype none

module trie_shortest_root_replacer #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_op,
    input  wire logic [tsr_pkg::SYM_W-1:0]  s_symbol,
    input  wire logic                       s_word_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [tsr_pkg::SYM_W-1:0]  m_out_symbol,
    output logic                            m_kept,
    output logic                            m_word_end,
    output logic                            m_table_overflow
);
    import tsr_pkg::*;

    tsr_cmd_t    cmd;
    tsr_status_t status;

    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tsr_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_op             (s_op),
        .s_symbol         (s_symbol),
        .s_word_last      (s_word_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_symbol     (m_out_symbol),
        .m_kept           (m_kept),
        .m_word_end       (m_word_end),
        .m_table_overflow (m_table_overflow)
    );

endmodule

`default_nettype wire

// ----- dv/tsr_tb_pkg.sv -----
package tsr_tb_pkg;

    // Kind of letter carried by one input item.
    typedef enum logic {
        OP_ROOT = 1'b0,
        OP_TEXT = 1'b1
    } sym_op_t;

endpackage

// ----- dv/tsr_checker.sv -----
module tsr_checker #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_op,
    input  logic [tsr_pkg::SYM_W-1:0] s_symbol,
    input  logic                      s_word_last,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [tsr_pkg::SYM_W-1:0] m_out_symbol,
    input  logic                      m_kept,
    input  logic                      m_word_end,
    input  logic                      m_table_overflow,
    output int                        fail_count,
    output int                        pending_letters,
    output int                        letters_checked,
    output int                        letters_dropped,
    output logic                      overflow_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tsr_pkg::*;
    import tsr_tb_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam bit [NODE_W-1:0] ROOT_NODE = '0;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             kept;
        logic             word_end;
        logic             overflow;
    } letter_result_t;

    // Shadow copy of the trie and of both cursors.
    bit [NODE_W-1:0] child_of [NODE_COUNT*ALPHABET_SIZE];
    bit              root_mark [NODE_COUNT];
    bit [NODE_W:0]   nodes_used;
    bit [NODE_W-1:0] load_node;
    bit              root_discard;
    bit [NODE_W-1:0] walk_node;
    match_mode_t     walk_mode;
    bit              table_full_seen;

    letter_result_t  expected_letters[$];
    letter_result_t  want;
    int              n_fail;
    int              n_checked;
    int              n_dropped;

    assign fail_count      = n_fail;
    assign letters_checked = n_checked;
    assign letters_dropped = n_dropped;
    assign overflow_seen   = table_full_seen;

    function automatic void clear_trie();
        foreach (child_of[i]) child_of[i] = ROOT_NODE;
        foreach (root_mark[i]) root_mark[i] = 1'b0;
        nodes_used      = 1;
        load_node       = ROOT_NODE;
        root_discard    = 1'b0;
        walk_node       = ROOT_NODE;
        walk_mode       = MODE_MATCH;
        table_full_seen = 1'b0;
    endfunction

    function automatic void load_root_letter(logic [SYM_W-1:0] sym, logic last);
        int idx;
        if (!root_discard) begin
            if (sym >= ALPHABET_SIZE) begin
                root_discard = 1'b1;
            end else begin
                idx = int'(load_node) * ALPHABET_SIZE + int'(sym);
                if (child_of[idx] == ROOT_NODE) begin
                    // A full table drops the rest of this root, but the nodes it
                    // already created stay in place without an end mark.
                    if (nodes_used >= NODE_COUNT) begin
                        table_full_seen = 1'b1;
                        root_discard    = 1'b1;
                    end else begin
                        child_of[idx] = nodes_used[NODE_W-1:0];
                        nodes_used++;
                    end
                end
                if (!root_discard) load_node = child_of[idx];
            end
        end
        if (last) begin
            if (!root_discard) root_mark[load_node] = 1'b1;
            load_node    = ROOT_NODE;
            root_discard = 1'b0;
        end
    endfunction

    function automatic letter_result_t walk_text_letter(logic [SYM_W-1:0] sym, logic last);
        letter_result_t res;
        int idx;
        res.kept = 1'b1;
        case (walk_mode)
            MODE_MATCH: begin
                // The end mark is tested before the letter, so a word equal to a
                // root keeps all of its letters.
                if (root_mark[walk_node]) begin
                    walk_mode = MODE_DROP;
                    res.kept  = 1'b0;
                end else if (sym >= ALPHABET_SIZE) begin
                    walk_mode = MODE_COPY;
                end else begin
                    idx = int'(walk_node) * ALPHABET_SIZE + int'(sym);
                    if (child_of[idx] == ROOT_NODE) walk_mode = MODE_COPY;
                    else walk_node = child_of[idx];
                end
            end
            MODE_DROP: res.kept = 1'b0;
            default: res.kept = 1'b1;
        endcase
        res.symbol   = sym;
        res.word_end = last;
        res.overflow = table_full_seen;
        if (last) begin
            walk_node = ROOT_NODE;
            walk_mode = MODE_MATCH;
        end
        return res;
    endfunction

    function automatic void check_field(string name, int expected_val, int actual_val);
        if (expected_val != actual_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_val, actual_val);
            n_fail++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_trie();
            expected_letters.delete();
            n_fail    = 0;
            n_checked = 0;
            n_dropped = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_op == OP_TEXT) begin
                    expected_letters.insert(expected_letters.size(),
                                            walk_text_letter(s_symbol, s_word_last));
                end else begin
                    load_root_letter(s_symbol, s_word_last);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_letters.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual symbol %0d",
                             $time, m_out_symbol);
                    n_fail++;
                end else begin
                    want = expected_letters.pop_front();
                    check_field("out_symbol", want.symbol, m_out_symbol);
                    check_field("kept", want.kept, m_kept);
                    check_field("word_end", want.word_end, m_word_end);
                    check_field("table_overflow", want.overflow, m_table_overflow);
                    n_checked++;
                    if (!want.kept) n_dropped++;
                end
            end
        end
        pending_letters = expected_letters.size();
    end

endmodule

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsr_pkg::*;
    import tsr_tb_pkg::*;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic             s_op        = OP_ROOT;
    logic [SYM_W-1:0] s_symbol    = '0;
    logic             s_word_last = 1'b0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [SYM_W-1:0] m_out_symbol;
    logic             m_kept;
    logic             m_word_end;
    logic             m_table_overflow;

    int   fail_count;
    int   pending_letters;
    int   letters_checked;
    int   letters_dropped;
    logic overflow_seen;

    int   root_letters_sent = 0;
    int   text_letters_sent = 0;
    bit   steady_send       = 1'b0;
    logic [SYM_W-1:0] seq[$];

    trie_shortest_root_replacer #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_symbol         (s_symbol),
        .s_word_last      (s_word_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_symbol     (m_out_symbol),
        .m_kept           (m_kept),
        .m_word_end       (m_word_end),
        .m_table_overflow (m_table_overflow)
    );

    tsr_checker #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_symbol         (s_symbol),
        .s_word_last      (s_word_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_symbol     (m_out_symbol),
        .m_kept           (m_kept),
        .m_word_end       (m_word_end),
        .m_table_overflow (m_table_overflow),
        .fail_count       (fail_count),
        .pending_letters  (pending_letters),
        .letters_checked  (letters_checked),
        .letters_dropped  (letters_dropped),
        .overflow_seen    (overflow_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    // Letters mostly come from a small alphabet so that words run into roots.
    function automatic logic [SYM_W-1:0] pick_letter(int hi, int noise_pct);
        if ($urandom_range(0, 99) < noise_pct) return SYM_W'($urandom_range(0, 31));
        return SYM_W'($urandom_range(0, hi));
    endfunction

    task automatic make_seq(int len, int hi, int noise_pct);
        seq.delete();
        repeat (len) seq.insert(seq.size(), pick_letter(hi, noise_pct));
    endtask

    task automatic send_letter(sym_op_t op, logic [SYM_W-1:0] sym, logic last);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_symbol    <= sym;
        s_word_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_TEXT) text_letters_sent++;
        else root_letters_sent++;
    endtask

    task automatic send_seq(sym_op_t op);
        foreach (seq[i]) send_letter(op, seq[i], i == seq.size() - 1);
    endtask

    initial begin
        int run;
        int stall;
        wait (aresetn);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        int kind;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Roots: "cat", one cut short by an out-of-range letter, and "z".
        seq = '{5'd2, 5'd0, 5'd19};
        send_seq(OP_ROOT);
        seq = '{5'd2, 5'd31, 5'd5};
        send_seq(OP_ROOT);
        seq = '{5'd25};
        send_seq(OP_ROOT);
        // Exact root, longer word, mismatch, and out-of-range text letters.
        seq = '{5'd2, 5'd0, 5'd19};
        send_seq(OP_TEXT);
        seq = '{5'd2, 5'd0, 5'd19, 5'd23};
        send_seq(OP_TEXT);
        seq = '{5'd2, 5'd14, 5'd22};
        send_seq(OP_TEXT);
        seq = '{5'd30, 5'd0};
        send_seq(OP_TEXT);
        seq = '{5'd25, 5'd0};
        send_seq(OP_TEXT);
        seq = '{5'd25, 5'd31};
        send_seq(OP_TEXT);

        repeat (20) begin
            make_seq($urandom_range(1, 4), 4, 3);
            send_seq(OP_ROOT);
        end
        while (text_letters_sent < 350) begin
            if ($urandom_range(0, 19) == 0) steady_send = ~steady_send;
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                make_seq($urandom_range(1, 4), 4, 5);
                send_seq(OP_ROOT);
            end else if (kind < 92) begin
                make_seq($urandom_range(1, 6), 4, 4);
                send_seq(OP_TEXT);
            end else begin
                make_seq($urandom_range(1, 3), 31, 100);
                if (kind < 96) send_seq(OP_TEXT);
                else send_seq(OP_ROOT);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_letters == 0);
        repeat (20) @(posedge aclk);
        $display("Sent %0d root letters and %0d text letters; %0d results checked, %0d dropped.",
                 root_letters_sent, text_letters_sent, letters_checked, letters_dropped);
        $display("Node table overflow %s during the run.",
                 overflow_seen ? "was reached" : "was not reached");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tsr_pkg.sv
rtl/core/tsr_ram.sv
rtl/core/tsr_ctrl.sv
rtl/core/tsr_datapath.sv
rtl/core/trie_shortest_root_replacer.sv
dv/tsr_tb_pkg.sv
dv/tsr_checker.sv
dv/tb.sv
